/* src/mtp_pkg.sv */
// Shared types and constants for the MIDI track event parser.
package mtp_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] STATUS_META    = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
   localparam logic [7:0] STATUS_ESCAPE  = 8'hF7;
   localparam logic [7:0] META_END       = 8'h2F;
   localparam logic [7:0] META_TEMPO     = 8'h51;
   localparam logic [7:0] CC_VOLUME      = 8'd7;
   localparam logic [7:0] CC_PAN         = 8'd10;
   localparam logic [7:0] CC_SOUND_OFF   = 8'd120;
   localparam logic [7:0] CC_NOTES_OFF   = 8'd123;
   localparam logic [31:0] TEMPO_LEN     = 32'd3;

   localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
   localparam logic [3:0] HI_NOTE_ON   = 4'h9;
   localparam logic [3:0] HI_CONTROL   = 4'hB;
   localparam logic [3:0] HI_PROGRAM   = 4'hC;
   localparam logic [3:0] HI_PRESSURE  = 4'hD;
   localparam logic [3:0] HI_PITCH     = 4'hE;

   typedef enum logic [2:0] {
      KIND_NOTE_OFF  = 3'd0,
      KIND_NOTE_ON   = 3'd1,
      KIND_VOLUME    = 3'd2,
      KIND_PAN       = 3'd3,
      KIND_ALL_OFF   = 3'd4,
      KIND_PROGRAM   = 3'd5,
      KIND_TEMPO     = 3'd6,
      KIND_TRACK_END = 3'd7
   } kind_type;

   typedef enum logic [6:0] {
      PH_DELTA  = 7'b0000001,
      PH_STATUS = 7'b0000010,
      PH_DATA1  = 7'b0000100,
      PH_DATA2  = 7'b0001000,
      PH_LEN    = 7'b0010000,
      PH_BODY   = 7'b0100000,
      PH_TEMPO  = 7'b1000000
   } phase_type;

   typedef enum logic [1:0] {
      CTL_OTHER   = 2'd0,
      CTL_VOLUME  = 2'd1,
      CTL_PAN     = 2'd2,
      CTL_ALL_OFF = 2'd3
   } ctl_class_type;

   typedef enum logic [1:0] {
      META_OTHER     = 2'd0,
      META_IS_END    = 2'd1,
      META_IS_TEMPO  = 2'd2
   } meta_class_type;

   typedef struct packed {
      logic [7:0]     track_byte;
      logic           track_restart;
      logic           last_byte;
      ctl_class_type  ctl_class;
      meta_class_type meta_class;
   } item_type;

endpackage

/* src/mtp_if.sv */
// Request and response channel interfaces of the MIDI track event parser.
interface mtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] track_byte;
   logic       track_restart;
   logic       last_byte;

   modport source (output valid, output track_byte, output track_restart,
                   output last_byte, input ready);
   modport sink (input valid, input track_byte, input track_restart,
                 input last_byte, output ready);
endinterface

interface mtp_rsp_if;
   logic              valid;
   logic              ready;
   mtp_pkg::kind_type event_kind;
   logic [3:0]        channel;
   logic [7:0]        note_number;
   logic [7:0]        event_value;
   logic [23:0]       tempo_us;
   logic [31:0]       event_tick;
   logic              track_done;

   modport source (output valid, output event_kind, output channel,
                   output note_number, output event_value, output tempo_us,
                   output event_tick, output track_done, input ready);
   modport sink (input valid, input event_kind, input channel,
                 input note_number, input event_value, input tempo_us,
                 input event_tick, input track_done, output ready);
endinterface

/* src/midi_track_event_parser.sv */
// Top level of the MIDI track event parser.
//
//   channel   dir   handshake       payload
//   req_chan  in    valid / ready   track_byte, track_restart, last_byte
//   rsp_chan  out   valid / ready   event_kind, channel, note_number, event_value,
//                                   tempo_us, event_tick, track_done
//
// One byte per cycle sustained while rsp_chan is not stalled; the parser handles one queued byte per cycle.
// After its byte is accepted, a result passes through two registers: the queue, then the output register.
// reset is synchronous: it empties the queue, clears the parse state and the output valid.
// A stalled response holds the parser; the byte queue (QueueDepth entries) keeps
// req_chan ready until it fills.
module midi_track_event_parser #(
   parameter int QueueDepth = mtp_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   mtp_req_if.sink   req_chan,
   mtp_rsp_if.source rsp_chan
);
   import mtp_pkg::*;

   logic     push;
   logic     pop;
   logic     queue_full;
   logic     queue_empty;
   item_type push_item;
   item_type head_item;

   mtp_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   mtp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   mtp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_item   (head_item),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

/* src/mtp_front.sv */
// Front end: accepts track bytes and tags controller and meta classes.
module mtp_front (
   mtp_req_if.sink           req_chan,
   input  logic              queue_full,
   output logic              push,
   output mtp_pkg::item_type push_item
);
   import mtp_pkg::*;

   ctl_class_type  ctl_class;
   meta_class_type meta_class;

   always_comb begin
      case (req_chan.track_byte)
         CC_VOLUME:                  ctl_class = CTL_VOLUME;
         CC_PAN:                     ctl_class = CTL_PAN;
         CC_SOUND_OFF, CC_NOTES_OFF: ctl_class = CTL_ALL_OFF;
         default:                    ctl_class = CTL_OTHER;
      endcase
   end

   always_comb begin
      case (req_chan.track_byte)
         META_END:   meta_class = META_IS_END;
         META_TEMPO: meta_class = META_IS_TEMPO;
         default:    meta_class = META_OTHER;
      endcase
   end

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   assign push_item.track_byte    = req_chan.track_byte;
   assign push_item.track_restart = req_chan.track_restart;
   assign push_item.last_byte     = req_chan.last_byte;
   assign push_item.ctl_class     = ctl_class;
   assign push_item.meta_class    = meta_class;

endmodule

/* src/mtp_queue.sv */
// Small flop FIFO between the front end and the parser.
module mtp_queue #(
   parameter int Depth = mtp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mtp_pkg::item_type push_item,
   input  logic              pop,
   output mtp_pkg::item_type head_item,
   output logic              full,
   output logic              empty
);
   import mtp_pkg::*;

   localparam int PtrWidth = $clog2(Depth);
   localparam int CntWidth = $clog2(Depth + 1);

   item_type              entry_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign full      = (count_ff == CntWidth'(Depth));
   assign empty     = (count_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/mtp_back.sv */
// Back end: parse state machine, tick counter and response register.
module mtp_back (
   input  logic              clock,
   input  logic              reset,
   input  mtp_pkg::item_type head_item,
   input  logic              queue_empty,
   output logic              pop,
   mtp_rsp_if.source         rsp_chan
);
   import mtp_pkg::*;

   phase_type      phase_ff, phase_in, phase_cur;
   logic [7:0]     status_ff, status_in, status_cur;
   logic [31:0]    tick_ff, tick_in, tick_cur;
   logic [31:0]    lacc_ff, lacc_in, lacc_cur;
   logic [31:0]    remain_ff, remain_in, remain_cur;
   meta_class_type meta_ff, meta_in, meta_cur;
   logic [7:0]     first_ff, first_in, first_cur;
   ctl_class_type  first_cls_ff, first_cls_in, first_cls_cur;
   logic [23:0]    tempo_ff, tempo_in, tempo_cur;
   logic [1:0]     index_ff, index_in, index_cur;
   logic           fin_ff, fin_in, fin_cur;

   logic           out_valid_ff, out_valid_in;
   kind_type       kind_ff, kind_in;
   logic [3:0]     chan_ff, chan_in;
   logic [7:0]     note_ff, note_in;
   logic [7:0]     value_ff, value_in;
   logic [23:0]    tempo_us_ff, tempo_us_in;
   logic [31:0]    out_tick_ff;
   logic           done_ff, done_in;
   logic           have;

   logic [7:0]     b;
   logic [3:0]     hi;
   logic [31:0]    acc_base;
   logic [31:0]    vlq;
   logic [31:0]    remain_dec;
   logic [23:0]    tempo_shift;
   logic [1:0]     index_inc;
   logic           do_first, do_delta, do_len, do_finish;
   logic [7:0]     d1, d2;
   ctl_class_type  d1_cls;
   logic           can_step, step;

   assign b = head_item.track_byte;

   // a restart byte sees the reset state
   assign phase_cur     = head_item.track_restart ? PH_DELTA   : phase_ff;
   assign status_cur    = head_item.track_restart ? 8'd0       : status_ff;
   assign tick_cur      = head_item.track_restart ? 32'd0      : tick_ff;
   assign lacc_cur      = head_item.track_restart ? 32'd0      : lacc_ff;
   assign remain_cur    = head_item.track_restart ? 32'd0      : remain_ff;
   assign meta_cur      = head_item.track_restart ? META_OTHER : meta_ff;
   assign first_cur     = head_item.track_restart ? 8'd0       : first_ff;
   assign first_cls_cur = head_item.track_restart ? CTL_OTHER  : first_cls_ff;
   assign tempo_cur     = head_item.track_restart ? 24'd0      : tempo_ff;
   assign index_cur     = head_item.track_restart ? 2'd0       : index_ff;
   assign fin_cur       = head_item.track_restart ? 1'b0       : fin_ff;

   assign hi          = status_cur[7:4];
   // a quantity that starts from a data byte in the status phases starts empty
   assign acc_base    = (phase_cur == PH_STATUS || phase_cur == PH_DATA1) ? 32'd0 : lacc_cur;
   assign vlq         = {acc_base[24:0], b[6:0]};
   assign remain_dec  = remain_cur - 32'd1;
   assign tempo_shift = {tempo_cur[15:0], b};
   assign index_inc   = index_cur + 2'd1;

   always_comb begin
      phase_in     = phase_cur;
      status_in    = status_cur;
      tick_in      = tick_cur;
      lacc_in      = lacc_cur;
      remain_in    = remain_cur;
      meta_in      = meta_cur;
      first_in     = first_cur;
      first_cls_in = first_cls_cur;
      tempo_in     = tempo_cur;
      index_in     = index_cur;
      fin_in       = fin_cur;
      have         = 1'b0;
      kind_in      = KIND_NOTE_OFF;
      chan_in      = 4'd0;
      note_in      = 8'd0;
      value_in     = 8'd0;
      tempo_us_in  = 24'd0;
      done_in      = 1'b0;
      do_first     = 1'b0;
      do_delta     = 1'b0;
      do_len       = 1'b0;
      do_finish    = 1'b0;
      d1           = 8'd0;
      d2           = 8'd0;
      d1_cls       = CTL_OTHER;

      if (!fin_cur) begin
         case (phase_cur)
            PH_DELTA: do_delta = 1'b1;
            PH_STATUS: begin
               if (b[7]) begin
                  status_in = b;
                  phase_in  = PH_DATA1;
               end else begin
                  do_first = 1'b1;
               end
            end
            PH_DATA1: do_first = 1'b1;
            PH_DATA2: begin
               do_finish = 1'b1;
               d1        = first_cur;
               d1_cls    = first_cls_cur;
               d2        = b;
            end
            PH_LEN: do_len = 1'b1;
            PH_BODY: begin
               remain_in = remain_dec;
               if (remain_dec == 32'd0) begin
                  phase_in = PH_DELTA;
               end
            end
            PH_TEMPO: begin
               tempo_in = tempo_shift;
               index_in = index_inc;
               if (index_inc == 2'd3) begin
                  index_in = 2'd0;
                  phase_in = PH_DELTA;
                  if (tempo_shift != 24'd0) begin
                     have        = 1'b1;
                     kind_in     = KIND_TEMPO;
                     tempo_us_in = tempo_shift;
                  end
               end
            end
            default: do_delta = 1'b1;
         endcase

         if (do_first) begin
            if (hi inside {[HI_NOTE_OFF:HI_PITCH]}) begin
               if (hi == HI_PROGRAM || hi == HI_PRESSURE) begin
                  do_finish = 1'b1;
                  d1        = b;
                  d1_cls    = head_item.ctl_class;
               end else begin
                  first_in     = b;
                  first_cls_in = head_item.ctl_class;
                  phase_in     = PH_DATA2;
               end
            end else if (status_cur == STATUS_META) begin
               meta_in  = head_item.meta_class;
               lacc_in  = 32'd0;
               phase_in = PH_LEN;
            end else if (status_cur == STATUS_SYSEX || status_cur == STATUS_ESCAPE) begin
               do_len = 1'b1;
            end else begin
               do_delta = 1'b1;
            end
         end

         if (do_delta) begin
            phase_in = PH_DELTA;
            lacc_in  = vlq;
            if (!b[7]) begin
               tick_in  = tick_cur + vlq;
               lacc_in  = 32'd0;
               phase_in = PH_STATUS;
            end
         end

         if (do_len) begin
            phase_in = PH_LEN;
            lacc_in  = vlq;
            if (!b[7]) begin
               lacc_in  = 32'd0;
               phase_in = PH_DELTA;
               if (status_cur == STATUS_META && meta_cur == META_IS_END) begin
                  have    = 1'b1;
                  kind_in = KIND_TRACK_END;
                  fin_in  = 1'b1;
               end else if (status_cur == STATUS_META && meta_cur == META_IS_TEMPO &&
                            vlq == TEMPO_LEN) begin
                  tempo_in = 24'd0;
                  index_in = 2'd0;
                  phase_in = PH_TEMPO;
               end else begin
                  remain_in = vlq;
                  if (vlq != 32'd0) begin
                     phase_in = PH_BODY;
                  end
               end
            end
         end

         if (do_finish) begin
            phase_in = PH_DELTA;
            chan_in  = status_cur[3:0];
            case (hi)
               HI_NOTE_OFF: begin
                  have     = 1'b1;
                  kind_in  = KIND_NOTE_OFF;
                  note_in  = d1;
                  value_in = d2;
               end
               HI_NOTE_ON: begin
                  have     = 1'b1;
                  kind_in  = KIND_NOTE_ON;
                  note_in  = d1;
                  value_in = d2;
               end
               HI_CONTROL: begin
                  case (d1_cls)
                     CTL_VOLUME: begin
                        have     = 1'b1;
                        kind_in  = KIND_VOLUME;
                        value_in = d2;
                     end
                     CTL_PAN: begin
                        have     = 1'b1;
                        kind_in  = KIND_PAN;
                        value_in = d2;
                     end
                     CTL_ALL_OFF: begin
                        have    = 1'b1;
                        kind_in = KIND_ALL_OFF;
                     end
                     default: have = 1'b0;
                  endcase
               end
               HI_PROGRAM: begin
                  have    = 1'b1;
                  kind_in = KIND_PROGRAM;
                  note_in = d1;
               end
               default: have = 1'b0;
            endcase
         end

         done_in = fin_in;
         if (head_item.last_byte && !fin_in) begin
            fin_in  = 1'b1;
            done_in = 1'b1;
            if (!have) begin
               have        = 1'b1;
               kind_in     = KIND_TRACK_END;
               chan_in     = 4'd0;
               note_in     = 8'd0;
               value_in    = 8'd0;
               tempo_us_in = 24'd0;
            end
         end
      end
   end

   assign can_step     = !out_valid_ff || rsp_chan.ready;
   assign step         = can_step && !queue_empty;
   assign pop          = step;
   assign out_valid_in = can_step ? (step && have) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DELTA;
         status_ff    <= 8'd0;
         tick_ff      <= 32'd0;
         lacc_ff      <= 32'd0;
         remain_ff    <= 32'd0;
         meta_ff      <= META_OTHER;
         first_ff     <= 8'd0;
         first_cls_ff <= CTL_OTHER;
         tempo_ff     <= 24'd0;
         index_ff     <= 2'd0;
         fin_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (step) begin
            phase_ff     <= phase_in;
            status_ff    <= status_in;
            tick_ff      <= tick_in;
            lacc_ff      <= lacc_in;
            remain_ff    <= remain_in;
            meta_ff      <= meta_in;
            first_ff     <= first_in;
            first_cls_ff <= first_cls_in;
            tempo_ff     <= tempo_in;
            index_ff     <= index_in;
            fin_ff       <= fin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && have) begin
         kind_ff     <= kind_in;
         chan_ff     <= chan_in;
         note_ff     <= note_in;
         value_ff    <= value_in;
         tempo_us_ff <= tempo_us_in;
         out_tick_ff <= tick_in;
         done_ff     <= done_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.event_kind  = kind_ff;
   assign rsp_chan.channel     = chan_ff;
   assign rsp_chan.note_number = note_ff;
   assign rsp_chan.event_value = value_ff;
   assign rsp_chan.tempo_us    = tempo_us_ff;
   assign rsp_chan.event_tick  = out_tick_ff;
   assign rsp_chan.track_done  = done_ff;

endmodule

/* tb/midi_event_checker.sv */
`timescale 1ns / 1ps
// Event checker: follows the track parse state and compares every emitted event.
module midi_event_checker
   import mtp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mtp_req_if   req,
   mtp_rsp_if   rsp,
   output int   mismatches,
   output int   pending,
   output int   events_checked
);

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  chan;
      logic [7:0]  note;
      logic [7:0]  amount;
      logic [23:0] tempo;
      logic [31:0] tick;
      logic        done;
   } midi_event_type;

   midi_event_type pending_events[$];

   phase_type   phase;
   logic [7:0]  run_status;
   logic [7:0]  meta_byte;
   logic [7:0]  data1;
   logic [31:0] tick;
   logic [31:0] vlq_acc;
   logic [31:0] skip_left;
   logic [23:0] tempo_acc;
   logic [1:0]  tempo_count;
   logic        finished;

   logic           ev_hit;
   midi_event_type ev_new;

   int fail_total    = 0;
   int checked_total = 0;
   int pending_count = 0;

   assign mismatches     = fail_total;
   assign pending        = pending_count;
   assign events_checked = checked_total;

   function automatic void restart_track();
      phase       = PH_DELTA;
      run_status  = 8'h00;
      meta_byte   = 8'h00;
      data1       = 8'h00;
      tick        = 32'd0;
      vlq_acc     = 32'd0;
      skip_left   = 32'd0;
      tempo_acc   = 24'd0;
      tempo_count = 2'd0;
      finished    = 1'b0;
   endfunction

   function automatic void post_event(kind_type k, logic [3:0] c, logic [7:0] n,
                                      logic [7:0] a, logic [23:0] t);
      ev_hit        = 1'b1;
      ev_new.kind   = k;
      ev_new.chan   = c;
      ev_new.note   = n;
      ev_new.amount = a;
      ev_new.tempo  = t;
      ev_new.tick   = 32'd0;
      ev_new.done   = 1'b0;
   endfunction

   function automatic void take_delta(logic [7:0] b);
      vlq_acc = {vlq_acc[24:0], b[6:0]};
      if (!b[7]) begin
         tick    = tick + vlq_acc;
         vlq_acc = 32'd0;
         phase   = PH_STATUS;
      end
   endfunction

   function automatic void take_length(logic [7:0] b);
      logic [31:0] len;
      vlq_acc = {vlq_acc[24:0], b[6:0]};
      if (b[7]) return;
      len     = vlq_acc;
      vlq_acc = 32'd0;
      phase   = PH_DELTA;
      if (run_status == STATUS_META && meta_byte == META_END) begin
         post_event(KIND_TRACK_END, 4'd0, 8'd0, 8'd0, 24'd0);
         finished = 1'b1;
         return;
      end
      // only a three byte set-tempo body is decoded
      if (run_status == STATUS_META && meta_byte == META_TEMPO && len == TEMPO_LEN) begin
         tempo_acc   = 24'd0;
         tempo_count = 2'd0;
         phase       = PH_TEMPO;
         return;
      end
      skip_left = len;
      if (len != 32'd0) phase = PH_BODY;
   endfunction

   function automatic void close_message(logic [7:0] d1, logic [7:0] d2);
      logic [3:0] ch;
      ch    = run_status[3:0];
      phase = PH_DELTA;
      case (run_status[7:4])
         HI_NOTE_OFF: post_event(KIND_NOTE_OFF, ch, d1, d2, 24'd0);
         HI_NOTE_ON:  post_event(KIND_NOTE_ON, ch, d1, d2, 24'd0);
         HI_CONTROL: begin
            if (d1 == CC_VOLUME)
               post_event(KIND_VOLUME, ch, 8'd0, d2, 24'd0);
            else if (d1 == CC_PAN)
               post_event(KIND_PAN, ch, 8'd0, d2, 24'd0);
            else if (d1 == CC_SOUND_OFF || d1 == CC_NOTES_OFF)
               post_event(KIND_ALL_OFF, ch, 8'd0, 8'd0, 24'd0);
         end
         HI_PROGRAM:  post_event(KIND_PROGRAM, ch, d1, 8'd0, 24'd0);
         default: ;
      endcase
   endfunction

   function automatic void first_data(logic [7:0] b);
      logic [3:0] hi;
      hi = run_status[7:4];
      if (hi >= HI_NOTE_OFF && hi <= HI_PITCH) begin
         if (hi == HI_PROGRAM || hi == HI_PRESSURE) begin
            close_message(b, 8'd0);
         end else begin
            data1 = b;
            phase = PH_DATA2;
         end
      end else if (run_status == STATUS_META) begin
         meta_byte = b;
         vlq_acc   = 32'd0;
         phase     = PH_LEN;
      end else if (run_status == STATUS_SYSEX || run_status == STATUS_ESCAPE) begin
         vlq_acc = 32'd0;
         phase   = PH_LEN;
         take_length(b);
      end else begin
         // no usable status: the byte opens a new delta
         vlq_acc = 32'd0;
         phase   = PH_DELTA;
         take_delta(b);
      end
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      case (phase)
         PH_DELTA: take_delta(b);
         PH_STATUS: begin
            if (b[7]) begin
               run_status = b;
               phase      = PH_DATA1;
            end else begin
               first_data(b);
            end
         end
         PH_DATA1: first_data(b);
         PH_DATA2: close_message(data1, b);
         PH_LEN:   take_length(b);
         PH_BODY: begin
            skip_left = skip_left - 32'd1;
            if (skip_left == 32'd0) phase = PH_DELTA;
         end
         PH_TEMPO: begin
            tempo_acc   = {tempo_acc[15:0], b};
            tempo_count = tempo_count + 2'd1;
            if (tempo_count == 2'd3) begin
               tempo_count = 2'd0;
               phase       = PH_DELTA;
               if (tempo_acc != 24'd0)
                  post_event(KIND_TEMPO, 4'd0, 8'd0, 8'd0, tempo_acc);
            end
         end
         default: begin
            phase = PH_DELTA;
            take_delta(b);
         end
      endcase
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         fail_total++;
      end
   endfunction

   always @(posedge clock) begin : watch
      logic           done_now;
      midi_event_type want;
      if (reset) begin
         restart_track();
         pending_events.delete();
      end else begin
         if (req.valid && req.ready) begin
            if (req.track_restart) restart_track();
            if (!finished) begin
               ev_hit = 1'b0;
               parse_byte(req.track_byte);
               done_now = finished;
               // last byte closes the track; a silent byte turns into a track end
               if (req.last_byte && !finished) begin
                  finished = 1'b1;
                  done_now = 1'b1;
                  if (!ev_hit) post_event(KIND_TRACK_END, 4'd0, 8'd0, 8'd0, 24'd0);
               end
               if (ev_hit) begin
                  ev_new.tick = tick;
                  ev_new.done = done_now;
                  pending_events.push_back(ev_new);
               end
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_events.size() == 0) begin
               $error("unexpected event: kind %0d tick 0x%0h", rsp.event_kind, rsp.event_tick);
               fail_total++;
            end else begin
               want = pending_events.pop_front();
               checked_total++;
               check_field("event_kind", 32'(want.kind), 32'(rsp.event_kind));
               check_field("channel", 32'(want.chan), 32'(rsp.channel));
               check_field("note_number", 32'(want.note), 32'(rsp.note_number));
               check_field("event_value", 32'(want.amount), 32'(rsp.event_value));
               check_field("tempo_us", 32'(want.tempo), 32'(rsp.tempo_us));
               check_field("event_tick", want.tick, rsp.event_tick);
               check_field("track_done", 32'(want.done), 32'(rsp.track_done));
            end
         end
      end
      pending_count = pending_events.size();
   end

endmodule

/* tb/tb_midi_track_event_parser.sv */
`timescale 1ns / 1ps
// Testbench top: clock, reset, track byte stimulus, response stalls and the verdict.
module tb_midi_track_event_parser;
   import mtp_pkg::*;

   localparam int RANDOM_ITEMS  = 1950;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 16;
   localparam logic [3:0] HI_AFTERTOUCH = 4'hA;

   logic clock;
   logic reset;

   int mismatches;
   int pending;
   int events_checked;

   int cycle_count = 0;
   int bytes_sent  = 0;
   int tracks_sent = 0;
   int burst_left  = 0;
   int rx_cycle    = 0;
   int rx_mode     = 0;

   logic [7:0] track_q[$];
   logic [7:0] last_status;

   mtp_req_if req_chan();
   mtp_rsp_if rsp_chan();

   midi_track_event_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   midi_event_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .rsp            (rsp_chan),
      .mismatches     (mismatches),
      .pending        (pending),
      .events_checked (events_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // response side: free running, random, periodic or mostly stalled
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 256 == 255) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
         0:       rsp_chan.ready <= 1'b1;
         1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
         2:       rsp_chan.ready <= (rx_cycle % 7) >= 3;
         default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic send_byte(input logic [7:0] b, input logic restart_bit, input logic last_bit);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 15) == 0) ? 150 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid         <= 1'b1;
      req_chan.track_byte    <= b;
      req_chan.track_restart <= restart_bit;
      req_chan.last_byte     <= last_bit;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_track(input logic with_restart, input int last_idx, input int content_len);
      for (int i = 0; i < track_q.size(); i++) begin
         send_byte(track_q[i], with_restart && i == 0, i == last_idx);
         if (i < content_len) bytes_sent++;
      end
      tracks_sent++;
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_data();
      return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                         : 8'($urandom_range(0, 127));
   endfunction

   function automatic void put_vlq(logic [31:0] v);
      logic [6:0] grp [0:4];
      int n;
      n = 0;
      do begin
         grp[n] = v[6:0];
         v = v >> 7;
         n++;
      end while (v != 32'd0);
      for (int i = n - 1; i >= 0; i--) track_q.push_back({i != 0, grp[i]});
   endfunction

   function automatic void put_delta();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: put_vlq($urandom_range(0, 127));
         6, 7:             put_vlq($urandom_range(128, 16383));
         8:                put_vlq($urandom());
         default: begin
            // extra leading groups: the quantity may overflow 32 bits
            repeat ($urandom_range(1, 2)) track_q.push_back(8'($urandom_range(128, 255)));
            put_vlq($urandom());
         end
      endcase
   endfunction

   function automatic void put_body(int n);
      repeat (n) track_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   // one delta plus one message; returns 1 when the message is an end of track
   function automatic bit add_event();
      logic [7:0] st;
      logic [7:0] first;
      logic [7:0] meta;
      int         len;
      bit         reuse;
      put_delta();
      case ($urandom_range(0, 17))
         0, 1:      st = {HI_NOTE_ON, 4'($urandom_range(0, 15))};
         2:         st = {HI_NOTE_OFF, 4'($urandom_range(0, 15))};
         3, 4:      st = {HI_CONTROL, 4'($urandom_range(0, 15))};
         5:         st = {HI_PROGRAM, 4'($urandom_range(0, 15))};
         6:         st = {HI_PRESSURE, 4'($urandom_range(0, 15))};
         7:         st = {HI_AFTERTOUCH, 4'($urandom_range(0, 15))};
         8:         st = {HI_PITCH, 4'($urandom_range(0, 15))};
         9:         st = STATUS_SYSEX;
         10:        st = STATUS_ESCAPE;
         11, 12, 13: st = STATUS_META;
         14:        st = 8'($urandom_range(241, 254));
         default:   st = (last_status != 8'h00) ? last_status : {HI_NOTE_ON, 4'h0};
      endcase
      reuse = (st == last_status) && ($urandom_range(0, 3) != 0);
      if (!reuse) track_q.push_back(st);
      last_status = st;
      if (st == STATUS_META) begin
         meta = ($urandom_range(0, 1) == 0) ? META_TEMPO : 8'($urandom_range(0, 127));
         track_q.push_back(meta);
         len = (meta == META_TEMPO && $urandom_range(0, 3) != 0) ? 3 : $urandom_range(0, 5);
         put_vlq(len);
         if (meta == META_END) return 1'b1;
         if (len == 3 && $urandom_range(0, 4) == 0) repeat (3) track_q.push_back(8'h00);
         else put_body(len);
      end else if (st == STATUS_SYSEX || st == STATUS_ESCAPE) begin
         len = $urandom_range(0, 6);
         put_vlq(len);
         put_body(len);
      end else if (st[7:4] >= HI_NOTE_OFF && st[7:4] <= HI_PITCH) begin
         // under running status a high first byte would read as a new status
         first = reuse ? 8'($urandom_range(0, 127)) : pick_data();
         if (st[7:4] == HI_CONTROL && $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 3))
               0:       first = CC_VOLUME;
               1:       first = CC_PAN;
               2:       first = CC_SOUND_OFF;
               default: first = CC_NOTES_OFF;
            endcase
         end
         track_q.push_back(first);
         if (st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE)
            track_q.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : pick_data());
      end
      return 1'b0;
   endfunction

   initial begin
      int  nev;
      int  cut;
      int  last_idx;
      int  content_len;
      int  directed_bytes;
      bit  ended;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.track_byte    = 8'h00;
      req_chan.track_restart = 1'b0;
      req_chan.last_byte     = 1'b0;
      rsp_chan.ready         = 1'b0;
      last_status            = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero velocity note on, long delta with running status, all notes off,
      // program with a high data byte, zero tempo
      track_q = '{8'h00, 8'h9F, 8'h00, 8'h00, 8'hFF, 8'h7F, 8'h3C, 8'h7F,
                  8'h00, 8'hB0, 8'h7B, 8'h00, 8'h00, 8'hC3, 8'hFF,
                  8'h00, 8'hFF, 8'h51, 8'h03, 8'h00, 8'h00, 8'h00};
      send_track(1'b1, -1, track_q.size());
      // end of track meta, then a byte that must be ignored
      track_q = '{8'h05, 8'hFF, 8'h2F, 8'h00, 8'h12};
      send_track(1'b1, -1, 4);
      // data byte with no running status, then last byte mid track
      track_q = '{8'h2A, 8'h10};
      send_track(1'b1, 1, 2);
      drain_results();
      directed_bytes = bytes_sent;

      while (bytes_sent - directed_bytes < RANDOM_ITEMS) begin
         track_q.delete();
         last_status = 8'h00;
         ended = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 24)) track_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            nev = $urandom_range(1, 12);
            for (int e = 0; e < nev && !ended; e++) ended = add_event();
         end
         last_idx = -1;
         case ($urandom_range(0, 3))
            0: begin
               if (!ended) begin
                  put_delta();
                  track_q.push_back(STATUS_META);
                  track_q.push_back(META_END);
                  track_q.push_back(8'h00);
                  ended = 1'b1;
               end
            end
            1: last_idx = track_q.size() - 1;
            2: begin
               cut = $urandom_range(1, track_q.size());
               while (track_q.size() > cut) void'(track_q.pop_back());
               last_idx = cut - 1;
            end
            default: begin
               // cut short with no last flag; the next restart lands mid message
               cut = $urandom_range(1, track_q.size());
               while (track_q.size() > cut) void'(track_q.pop_back());
            end
         endcase
         content_len = track_q.size();
         if (ended) repeat ($urandom_range(0, 2)) track_q.push_back(8'($urandom_range(0, 255)));
         send_track($urandom_range(0, 9) != 0, last_idx, content_len);
         if (tracks_sent % 40 == 0) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d track bytes in %0d tracks: channel events, tempo, meta and",
               bytes_sent, tracks_sent);
      $display("SysEx skips, running status, cut-short tracks; %0d events checked.",
               events_checked);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
